// ===== hdl/bbgm_pkg.sv =====
// Shared constants for the block brightness glyph mapper.
package bbgm_pkg;

  // Default sizing
  localparam int unsigned MaxWidthDef = 1024;
  localparam int unsigned MaxBlockDef = 8;

  // Fixed field widths
  localparam int unsigned ImageWidthW  = 11;
  localparam int unsigned ImageHeightW = 13;
  localparam int unsigned BlockSizeW   = 4;
  localparam int unsigned CharMapW     = 64;
  localparam int unsigned GrayW        = 8;
  localparam int unsigned GlyphW       = 8;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;

  // Row counter limit
  localparam int unsigned HeightLimit = 4096;
  localparam int unsigned PixelRowW   = 12;

  // Brightness levels: eight glyphs, level = average >> 5
  localparam int unsigned NumLevels  = 8;
  localparam int unsigned LevelW     = 3;
  localparam int unsigned LevelShift = 5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBlockWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBlockHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCharMap     = 3'd4;

  // Reset values
  localparam logic [ImageWidthW-1:0]  ImageWidthRst  = 11'd640;
  localparam logic [ImageHeightW-1:0] ImageHeightRst = 13'd480;
  localparam logic [BlockSizeW-1:0]   BlockWidthRst  = 4'd2;
  localparam logic [BlockSizeW-1:0]   BlockHeightRst = 4'd2;
  localparam logic [CharMapW-1:0]     CharMapRst     = 64'd0;

endpackage

// ===== hdl/block_brightness_glyph_mapper.sv =====
// Top level: block averaging of raster gray pixels into glyph codes.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, gray_i           | pixel in
//   out     | out_valid_o, out_stall_i, glyph_o,       | glyph out
//           | row_end_o                                |
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i          | write only
//
// One pixel per cycle sustained while the output does not stall. A pixel reads
// its block-column sum from the sum memory at accept; as the stage advances it
// adds, writes back and loads a finished block into the output register.
// Back-to-back pixels in the same block column take the sum from a bypass.
// Reset clears counters and valids; the sum memory needs no clearing pass.
// A stalled output register holds the compute stage, which then stalls input.
module block_brightness_glyph_mapper
  import bbgm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDef,
  parameter int unsigned MAX_BLOCK = MaxBlockDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [GrayW-1:0]    gray_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [GlyphW-1:0]   glyph_o,
  output logic                row_end_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned PcW   = $clog2(MAX_WIDTH);
  localparam int unsigned IxW   = ((PcW > ImageWidthW) ? PcW : ImageWidthW) + 1;
  localparam int unsigned BcW   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int unsigned BxW   = ((BcW > BlockSizeW) ? BcW : BlockSizeW) + 1;
  localparam int unsigned HxW   = ImageHeightW + 1;
  localparam int unsigned CntW  = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
  localparam int unsigned SumW  = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
  localparam int unsigned ThW   = CntW + LevelW + LevelShift;

  // Configuration registers
  logic [ImageWidthW-1:0]  image_width_q;
  logic [ImageHeightW-1:0] image_height_q;
  logic [BlockSizeW-1:0]   block_width_q;
  logic [BlockSizeW-1:0]   block_height_q;
  logic [CharMapW-1:0]     char_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= ImageWidthRst;
      image_height_q <= ImageHeightRst;
      block_width_q  <= BlockWidthRst;
      block_height_q <= BlockHeightRst;
      char_map_q     <= CharMapRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegImageWidth:  image_width_q  <= cfg_data_i[ImageWidthW-1:0];
        RegImageHeight: image_height_q <= cfg_data_i[ImageHeightW-1:0];
        RegBlockWidth:  block_width_q  <= cfg_data_i[BlockSizeW-1:0];
        RegBlockHeight: block_height_q <= cfg_data_i[BlockSizeW-1:0];
        RegCharMap:     char_map_q     <= cfg_data_i[CharMapW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped limits, minus one
  logic [IxW-1:0] iw_x, w_m1;
  logic [HxW-1:0] ih_x, h_m1;
  logic [BxW-1:0] bw_x, bh_x, bw_m1, bh_m1;

  always_comb begin
    iw_x = IxW'(image_width_q);
    ih_x = HxW'(image_height_q);
    bw_x = BxW'(block_width_q);
    bh_x = BxW'(block_height_q);
    if (iw_x == '0)                  w_m1 = '0;
    else if (iw_x > IxW'(MAX_WIDTH)) w_m1 = IxW'(MAX_WIDTH - 1);
    else                             w_m1 = iw_x - IxW'(1);
    if (ih_x == '0)                    h_m1 = '0;
    else if (ih_x > HxW'(HeightLimit)) h_m1 = HxW'(HeightLimit - 1);
    else                               h_m1 = ih_x - HxW'(1);
    if (bw_x == '0)                  bw_m1 = '0;
    else if (bw_x > BxW'(MAX_BLOCK)) bw_m1 = BxW'(MAX_BLOCK - 1);
    else                             bw_m1 = bw_x - BxW'(1);
    if (bh_x == '0)                  bh_m1 = '0;
    else if (bh_x > BxW'(MAX_BLOCK)) bh_m1 = BxW'(MAX_BLOCK - 1);
    else                             bh_m1 = bh_x - BxW'(1);
  end

  // Raster position
  logic [PcW-1:0]       pixel_col_q, pixel_col_d;
  logic [PixelRowW-1:0] pixel_row_q, pixel_row_d;
  logic [BcW-1:0]       col_in_blk_q, col_in_blk_d;
  logic [BcW-1:0]       row_in_blk_q, row_in_blk_d;
  logic [PcW-1:0]       blk_col_q, blk_col_d;

  logic row_last, col_last, frame_row_last, blk_row_last;
  logic in_acc;

  assign row_last       = IxW'(pixel_col_q) >= w_m1;
  assign col_last       = BxW'(col_in_blk_q) >= bw_m1;
  assign frame_row_last = HxW'(pixel_row_q) >= h_m1;
  assign blk_row_last   = BxW'(row_in_blk_q) >= bh_m1;

  always_comb begin
    pixel_col_d  = pixel_col_q;
    pixel_row_d  = pixel_row_q;
    col_in_blk_d = col_in_blk_q;
    row_in_blk_d = row_in_blk_q;
    blk_col_d    = blk_col_q;
    if (row_last) begin
      pixel_col_d  = '0;
      col_in_blk_d = '0;
      blk_col_d    = '0;
      if (frame_row_last) begin
        pixel_row_d  = '0;
        row_in_blk_d = '0;
      end else begin
        pixel_row_d  = pixel_row_q + PixelRowW'(1);
        row_in_blk_d = blk_row_last ? '0 : row_in_blk_q + BcW'(1);
      end
    end else begin
      pixel_col_d = pixel_col_q + PcW'(1);
      if (col_last) begin
        col_in_blk_d = '0;
        blk_col_d    = blk_col_q + PcW'(1);
      end else begin
        col_in_blk_d = col_in_blk_q + BcW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_col_q  <= '0;
      pixel_row_q  <= '0;
      col_in_blk_q <= '0;
      row_in_blk_q <= '0;
      blk_col_q    <= '0;
    end else if (in_acc) begin
      pixel_col_q  <= pixel_col_d;
      pixel_row_q  <= pixel_row_d;
      col_in_blk_q <= col_in_blk_d;
      row_in_blk_q <= row_in_blk_d;
      blk_col_q    <= blk_col_d;
    end
  end

  // Pixel count of the block so far
  logic [BcW:0]      cols_used, rows_used;
  logic [CntW-1:0]   cnt_d;
  logic [2*BcW+1:0]  cnt_prod;

  assign cols_used = (BcW+1)'(col_in_blk_q) + (BcW+1)'(1);
  assign rows_used = (BcW+1)'(row_in_blk_q) + (BcW+1)'(1);
  assign cnt_prod  = (2*BcW+2)'(cols_used) * (2*BcW+2)'(rows_used);
  assign cnt_d     = CntW'(cnt_prod);

  // Compute stage
  logic             s1_vld_q;
  logic [GrayW-1:0] s1_gray_q;
  logic [PcW-1:0]   s1_idx_q;
  logic             s1_first_q;
  logic             s1_emit_q;
  logic             s1_row_end_q;
  logic [CntW-1:0]  s1_cnt_q;
  logic             s1_adv;
  logic             out_free;

  logic             out_vld_q;
  logic [GlyphW-1:0] glyph_q;
  logic             row_end_q;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_adv     = s1_vld_q && (!s1_emit_q || out_free);
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_gray_q    <= gray_i;
      s1_idx_q     <= blk_col_q;
      s1_first_q   <= (col_in_blk_q == '0) && (row_in_blk_q == '0);
      s1_emit_q    <= (row_last || col_last) && (frame_row_last || blk_row_last);
      s1_row_end_q <= row_last;
      s1_cnt_q     <= cnt_d;
    end
  end

  // Block-column sum memory
  logic [SumW-1:0] sum_mem [MAX_WIDTH];
  logic [SumW-1:0] rd_q;
  logic [SumW-1:0] sum_new;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      sum_mem[s1_idx_q] <= sum_new;
    end
    if (in_acc) begin
      rd_q <= sum_mem[blk_col_q];
    end
  end

  // Bypass of the last write, covers a read issued at the same edge
  logic            fwd_vld_q;
  logic [PcW-1:0]  fwd_idx_q;
  logic [SumW-1:0] fwd_val_q;
  logic            fwd_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (s1_adv) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fwd_idx_q <= s1_idx_q;
      fwd_val_q <= sum_new;
    end
  end

  assign fwd_hit = fwd_vld_q && (fwd_idx_q == s1_idx_q);

  // Accumulate; saturate so an overfull sum still reads as the top level
  logic [SumW-1:0] sum_base;
  logic [SumW:0]   sum_raw;

  always_comb begin
    sum_base = fwd_hit ? fwd_val_q : rd_q;
    sum_raw  = (SumW+1)'(sum_base) + (SumW+1)'(s1_gray_q);
    if (s1_first_q) begin
      sum_new = SumW'(s1_gray_q);
    end else if (sum_raw[SumW]) begin
      sum_new = '1;
    end else begin
      sum_new = sum_raw[SumW-1:0];
    end
  end

  // Level = floor(sum / count) >> 5, found by comparing against count * 32k
  logic [LevelW-1:0] level;
  logic [ThW-1:0]    thresh;

  always_comb begin
    level  = '0;
    thresh = '0;
    for (int k = 1; k < NumLevels; k++) begin
      thresh = (ThW'(s1_cnt_q) * ThW'(k)) << LevelShift;
      if (ThW'(sum_new) >= thresh) begin
        level = LevelW'(k);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv && s1_emit_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      glyph_q   <= char_map_q[GlyphW*level +: GlyphW];
      row_end_q <= s1_row_end_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign glyph_o     = glyph_q;
  assign row_end_o   = row_end_q;

  // Checks
  a_stall_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_vld_q && s1_emit_q && out_vld_q))
    else $error("input stalled without a blocked finished block");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_vld_q)
    else $error("accepted item did not reach the compute stage");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s1_adv && s1_emit_q))
    else $error("result appeared without a finished block");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IxW'(pixel_col_q) < IxW'(MAX_WIDTH)) && (blk_col_q <= pixel_col_q))
    else $error("column counters out of range");

  a_blk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (BxW'(col_in_blk_q) < BxW'(MAX_BLOCK)) && (BxW'(row_in_blk_q) < BxW'(MAX_BLOCK)))
    else $error("in-block counters out of range");

endmodule
